// ----- design/lbcf_pkg.sv -----
package lbcf_pkg;

	localparam int NUM_BLOCKS_DEF   = 8;
	localparam int BLOCK_BYTES_DEF  = 32;
	localparam int NUM_CHANNELS_DEF = 4;
	localparam int MAX_PEEK_DEF     = 64;

	localparam logic [7:0] FILL_LIMIT_RESET = 8'd248;
	localparam logic       REG_FILL_LIMIT   = 1'b0;

	localparam logic [1:0] CMD_PUT  = 2'd0;
	localparam logic [1:0] CMD_GET  = 2'd1;
	localparam logic [1:0] CMD_PEEK = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] channel;
		logic [7:0] write_byte;
		logic [6:0] peek_length;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       byte_valid;
		logic       accepted;
		logic [7:0] bytes_held;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic latch;
		logic decode;
		logic put_tail;
		logic get_link;
		logic get_data;
		logic peek_read;
		logic peek_link;
		logic peek_data;
	} dp_cmd_t;

	typedef struct packed {
		logic can_emit;
		logic decode_done;
		logic is_put;
		logic is_get;
		logic get_at_link;
		logic link_bad;
		logic peek_at_link;
		logic peek_first;
		logic peek_last;
	} dp_st_t;

endpackage

// ----- design/lbcf_ram.sv -----
module lbcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/lbcf_ctrl.sv -----
module lbcf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  lbcf_pkg::dp_st_t   st,
	output lbcf_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_PUT2   = 3'd2;
	localparam logic [2:0] S_GLINK  = 3'd3;
	localparam logic [2:0] S_GDATA  = 3'd4;
	localparam logic [2:0] S_PREAD  = 3'd5;
	localparam logic [2:0] S_PLINK  = 3'd6;
	localparam logic [2:0] S_PDATA  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.can_emit) begin
					cmd.decode = 1'b1;
					if (st.decode_done) state_d = S_IDLE;
					else if (st.is_put) state_d = S_PUT2;
					else if (st.is_get) state_d = st.get_at_link ? S_GLINK : S_GDATA;
					else state_d = S_PREAD;
				end
			end
			S_PUT2: begin
				if (st.can_emit) begin
					cmd.put_tail = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_GLINK: begin
				if (!st.link_bad) begin
					cmd.get_link = 1'b1;
					state_d = S_GDATA;
				end else if (st.can_emit) begin
					cmd.get_link = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_GDATA: begin
				if (st.can_emit) begin
					cmd.get_data = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_PREAD: begin
				cmd.peek_read = 1'b1;
				state_d = st.peek_at_link ? S_PLINK : S_PDATA;
			end
			S_PLINK: begin
				if (!(st.link_bad && st.peek_first)) begin
					cmd.peek_link = 1'b1;
					state_d = S_PDATA;
				end else if (st.can_emit) begin
					cmd.peek_link = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_PDATA: begin
				if (st.can_emit) begin
					cmd.peek_data = 1'b1;
					state_d = st.peek_last ? S_IDLE : S_PREAD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> state_q == S_DECODE)
		else $error("latched beat not decoded");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT2) |-> $past(state_q) == S_DECODE || $past(state_q) == S_PUT2)
		else $error("put tail entered out of order");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command");

endmodule

// ----- design/lbcf_dp.sv -----
module lbcf_dp #(
	parameter int NUM_BLOCKS   = lbcf_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES  = lbcf_pkg::BLOCK_BYTES_DEF,
	parameter int NUM_CHANNELS = lbcf_pkg::NUM_CHANNELS_DEF,
	parameter int MAX_PEEK     = lbcf_pkg::MAX_PEEK_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lbcf_pkg::req_t     req,
	input  logic [7:0]         fill_limit,
	input  lbcf_pkg::dp_cmd_t  cmd,
	output lbcf_pkg::dp_st_t   st,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output lbcf_pkg::rsp_t     rsp
);

	localparam int BW  = $clog2(NUM_BLOCKS);
	localparam int OFW = $clog2(BLOCK_BYTES);
	localparam int AW  = $clog2(NUM_BLOCKS * BLOCK_BYTES);
	localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [OFW-1:0] LINK_OFF = OFW'(BLOCK_BYTES - 1);
	localparam logic [6:0]     PEEK_MAX = 7'(MAX_PEEK);

	function automatic logic [AW-1:0] pool_addr(input logic [BW-1:0] b,
		input logic [OFW-1:0] o);
		return AW'(b) * AW'(BLOCK_BYTES) + AW'(o);
	endfunction

	lbcf_pkg::req_t item_q;
	logic [NUM_BLOCKS-1:0]   free_q;
	logic [NUM_CHANNELS-1:0] has_q;
	logic [7:0]     cnt_q  [NUM_CHANNELS];
	logic [BW-1:0]  wblk_q [NUM_CHANNELS];
	logic [OFW-1:0] woff_q [NUM_CHANNELS];
	logic [BW-1:0]  rblk_q [NUM_CHANNELS];
	logic [OFW-1:0] roff_q [NUM_CHANNELS];
	logic [BW-1:0]  chain_q;
	logic [BW-1:0]  pblk_q;
	logic [OFW-1:0] poff_q;
	logic [6:0]     pi_q;
	logic [6:0]     pn_q;
	logic           out_valid_q;
	lbcf_pkg::rsp_t out_q;

	logic [CHW-1:0] ch;
	logic           in_range;
	logic           has_c;
	logic [7:0]     cnt_c;
	logic [BW-1:0]  wblk_c;
	logic [OFW-1:0] woff_c;
	logic [BW-1:0]  rblk_c;
	logic [OFW-1:0] roff_c;
	logic [BW-1:0]  lf;
	logic           any_free;
	logic           is_put;
	logic           is_get;
	logic           is_peek;
	logic           put_chain;
	logic           put_refuse;
	logic           get_empty;
	logic [6:0]     plen;
	logic [6:0]     pn;
	logic [BW-1:0]  link_blk;
	logic           link_bad;
	logic           can_emit;
	logic           res_load;
	lbcf_pkg::rsp_t res;
	logic           mem_we;
	logic           mem_re;
	logic [AW-1:0]  mem_addr;
	logic [7:0]     mem_wdata;
	logic [7:0]     mem_rdata;

	assign ch       = CHW'(item_q.channel);
	assign in_range = 32'(item_q.channel) < NUM_CHANNELS;
	assign has_c    = has_q[ch];
	assign cnt_c    = cnt_q[ch];
	assign wblk_c   = wblk_q[ch];
	assign woff_c   = woff_q[ch];
	assign rblk_c   = rblk_q[ch];
	assign roff_c   = roff_q[ch];
	assign link_blk = BW'(mem_rdata);
	assign link_bad = 32'(mem_rdata) >= NUM_BLOCKS;
	assign can_emit = !out_valid_q || rsp_ready;

	always_comb begin
		lf = '0;
		for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
			if (free_q[b]) lf = BW'(b);
		end
	end
	assign any_free = |free_q;

	assign is_put     = in_range && item_q.command == lbcf_pkg::CMD_PUT;
	assign is_get     = in_range && item_q.command == lbcf_pkg::CMD_GET;
	assign is_peek    = in_range && item_q.command == lbcf_pkg::CMD_PEEK;
	assign put_chain  = has_c && woff_c == LINK_OFF;
	assign put_refuse = cnt_c > fill_limit || cnt_c == 8'hFF || !any_free && (!has_c || put_chain);
	assign get_empty  = cnt_c == 8'd0 || !has_c;
	assign plen       = (item_q.peek_length > PEEK_MAX) ? PEEK_MAX : item_q.peek_length;
	assign pn         = !has_c ? 7'd0 : (cnt_c > {1'b0, plen}) ? plen : cnt_c[6:0];

	assign st.can_emit     = can_emit;
	assign st.decode_done  = !in_range || item_q.command == lbcf_pkg::CMD_NONE
		|| (is_put && (put_refuse || !put_chain)) || (is_get && get_empty)
		|| (is_peek && pn == 7'd0);
	assign st.is_put       = is_put;
	assign st.is_get       = is_get;
	assign st.get_at_link  = roff_c == LINK_OFF;
	assign st.link_bad     = link_bad;
	assign st.peek_at_link = poff_q == LINK_OFF;
	assign st.peek_first   = pi_q == 7'd0;
	assign st.peek_last    = 7'(pi_q + 7'd1) == pn_q;

	// pool port and result selection
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = pool_addr(rblk_c, roff_c);
		mem_wdata = item_q.write_byte;
		res_load  = 1'b0;
		res       = '0;
		res.last  = 1'b1;
		if (cmd.decode) begin
			if (!in_range) begin
				res_load = 1'b1;
			end else if (is_put) begin
				res.bytes_held = cnt_c;
				if (!put_refuse) begin
					mem_we = 1'b1;
					if (!has_c) begin
						mem_addr = pool_addr(lf, '0);
					end else begin
						mem_addr = pool_addr(wblk_c, woff_c);
						if (put_chain) mem_wdata = 8'(lf);
					end
				end
				if (put_refuse || !put_chain) begin
					res_load = 1'b1;
					res.accepted = !put_refuse;
					res.bytes_held = put_refuse ? cnt_c : 8'(cnt_c + 8'd1);
				end
			end else if (is_get) begin
				if (get_empty) res_load = 1'b1;
				else mem_re = 1'b1;
			end else begin
				res.bytes_held = cnt_c;
				res_load = !is_peek || pn == 7'd0;
			end
		end
		if (cmd.put_tail) begin
			mem_we = 1'b1;
			mem_addr = pool_addr(chain_q, '0);
			res_load = 1'b1;
			res.accepted = 1'b1;
			res.bytes_held = 8'(cnt_c + 8'd1);
		end
		if (cmd.get_link) begin
			if (link_bad) begin
				res_load = 1'b1;
			end else begin
				mem_re = 1'b1;
				mem_addr = pool_addr(link_blk, '0);
			end
		end
		if (cmd.get_data) begin
			res_load = 1'b1;
			res.read_byte = mem_rdata;
			res.byte_valid = 1'b1;
			res.bytes_held = 8'(cnt_c - 8'd1);
		end
		if (cmd.peek_read) begin
			mem_re = 1'b1;
			mem_addr = pool_addr(pblk_q, poff_q);
		end
		if (cmd.peek_link) begin
			if (link_bad && pi_q == 7'd0) begin
				res_load = 1'b1;
				res.bytes_held = cnt_c;
			end else begin
				mem_re = 1'b1;
				mem_addr = pool_addr(link_blk, '0);
			end
		end
		if (cmd.peek_data) begin
			res_load = 1'b1;
			res.read_byte = mem_rdata;
			res.byte_valid = 1'b1;
			res.bytes_held = cnt_c;
			res.last = 7'(pi_q + 7'd1) == pn_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			has_q <= '0;
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				cnt_q[k]  <= '0;
				wblk_q[k] <= '0;
				woff_q[k] <= '0;
				rblk_q[k] <= '0;
				roff_q[k] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.decode && is_put && !put_refuse) begin
				free_q[lf] <= !has_c ? 1'b0 : (put_chain ? 1'b0 : free_q[lf]);
				if (!has_c) begin
					has_q[ch]  <= 1'b1;
					wblk_q[ch] <= lf;
					woff_q[ch] <= OFW'(1);
					rblk_q[ch] <= lf;
					roff_q[ch] <= '0;
					cnt_q[ch]  <= 8'(cnt_c + 8'd1);
				end else if (!put_chain) begin
					woff_q[ch] <= OFW'(woff_c + OFW'(1));
					cnt_q[ch]  <= 8'(cnt_c + 8'd1);
				end
			end
			if (cmd.decode && is_get && get_empty) begin
				has_q[ch]  <= 1'b0;
				wblk_q[ch] <= '0;
				woff_q[ch] <= '0;
				rblk_q[ch] <= '0;
				roff_q[ch] <= '0;
				cnt_q[ch]  <= '0;
			end
			if (cmd.put_tail) begin
				wblk_q[ch] <= chain_q;
				woff_q[ch] <= OFW'(1);
				cnt_q[ch]  <= 8'(cnt_c + 8'd1);
			end
			if (cmd.get_link) begin
				free_q[rblk_c] <= 1'b1;
				if (link_bad) begin
					has_q[ch]  <= 1'b0;
					wblk_q[ch] <= '0;
					woff_q[ch] <= '0;
					rblk_q[ch] <= '0;
					roff_q[ch] <= '0;
					cnt_q[ch]  <= '0;
				end else begin
					rblk_q[ch] <= link_blk;
					roff_q[ch] <= '0;
				end
			end
			if (cmd.get_data) begin
				if (cnt_c == 8'd1) begin
					free_q[rblk_c] <= 1'b1;
					has_q[ch]  <= 1'b0;
					wblk_q[ch] <= '0;
					woff_q[ch] <= '0;
					rblk_q[ch] <= '0;
					roff_q[ch] <= '0;
					cnt_q[ch]  <= '0;
				end else begin
					roff_q[ch] <= OFW'(roff_c + OFW'(1));
					cnt_q[ch]  <= 8'(cnt_c - 8'd1);
				end
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= req;
		end
		if (cmd.decode && is_put) begin
			chain_q <= lf;
		end
		if (cmd.decode && is_peek) begin
			pblk_q <= rblk_c;
			poff_q <= roff_c;
			pi_q   <= '0;
			pn_q   <= pn;
		end
		if (cmd.peek_link) begin
			pblk_q <= link_blk;
			poff_q <= '0;
		end
		if (cmd.peek_data) begin
			poff_q <= OFW'(poff_q + OFW'(1));
			pi_q   <= 7'(pi_q + 7'd1);
		end
		if (res_load) begin
			out_q <= res;
		end
	end

	lbcf_ram #(
		.WIDTH(8),
		.DEPTH(NUM_BLOCKS * BLOCK_BYTES)
	) u_pool (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("pool read and write in one cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put_tail |-> !free_q[chain_q])
		else $error("chained block still marked free");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.decode && is_get && get_empty) |=> cnt_q[ch] == 8'd0 && !has_q[ch])
		else $error("empty get left channel held");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> can_emit)
		else $error("result beat overwrote a waiting one");

endmodule

// ----- design/linked_block_channel_fifo.sv -----
// one item at a time: put is latch, decode, and a put tail step when it chains a new block
// get is latch, decode, a link step when it crosses a link byte, then data; empty get is latch and decode
// peek is latch, decode, then a read and a data step per byte returned, with a link step per link crossed
// each byte costs one access on the single-port pool memory, and each link byte crossed one more
// reset: free map all ones, channels released, fill_limit 248
// pool memory is not cleared; the result register parts the output side
module linked_block_channel_fifo #(
	parameter int NUM_BLOCKS   = lbcf_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES  = lbcf_pkg::BLOCK_BYTES_DEF,
	parameter int NUM_CHANNELS = lbcf_pkg::NUM_CHANNELS_DEF,
	parameter int MAX_PEEK     = lbcf_pkg::MAX_PEEK_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	input  logic            req_valid,
	output logic            req_ready,
	input  lbcf_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output lbcf_pkg::rsp_t  rsp
);

	logic [7:0]        fill_limit_q;
	lbcf_pkg::dp_cmd_t cmd;
	lbcf_pkg::dp_st_t  st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_limit_q <= lbcf_pkg::FILL_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == lbcf_pkg::REG_FILL_LIMIT) begin
			fill_limit_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == lbcf_pkg::REG_FILL_LIMIT) ? {24'd0, fill_limit_q} : 32'd0;

	lbcf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.st       (st),
		.cmd      (cmd)
	);

	lbcf_dp #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES),
		.NUM_CHANNELS(NUM_CHANNELS),
		.MAX_PEEK    (MAX_PEEK)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.fill_limit(fill_limit_q),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- bench/tb_linked_block_channel_fifo.sv -----
module tb_linked_block_channel_fifo;

	localparam int NBLK = lbcf_pkg::NUM_BLOCKS_DEF;
	localparam int BBYTES = lbcf_pkg::BLOCK_BYTES_DEF;
	localparam int NCH = lbcf_pkg::NUM_CHANNELS_DEF;
	localparam int MPEEK = lbcf_pkg::MAX_PEEK_DEF;
	localparam int POOL = NBLK * BBYTES;
	localparam int LINK_OFS = BBYTES - 1;
	localparam int CYCLE_LIMIT = 2000000;

	class pool_scoreboard;
		logic [7:0] pool_mem [POOL];
		logic [7:0] free_map;
		int wr_pos [NCH];
		int rd_pos [NCH];
		bit has_blk [NCH];
		int held [NCH];
		int limit;
		lbcf_pkg::rsp_t pending [$];
		int errors;

		function new();
			foreach (pool_mem[i]) pool_mem[i] = '0;
			free_map = '1;
			foreach (wr_pos[i]) begin
				wr_pos[i] = 0;
				rd_pos[i] = 0;
				has_blk[i] = 0;
				held[i] = 0;
			end
			limit = lbcf_pkg::FILL_LIMIT_RESET;
			errors = 0;
		endfunction

		function int grab_block();
			for (int b = 0; b < NBLK; b++) begin
				if (free_map[b]) begin
					free_map[b] = 0;
					pool_mem[b*BBYTES+LINK_OFS] = 0;
					return b;
				end
			end
			return -1;
		endfunction

		function void drop_chan(int c);
			has_blk[c] = 0;
			wr_pos[c] = 0;
			rd_pos[c] = 0;
		endfunction

		function void push_rsp(int b, int v, int a, int h, int l);
			lbcf_pkg::rsp_t r;
			r.read_byte = 8'(b);
			r.byte_valid = v[0];
			r.accepted = a[0];
			r.bytes_held = 8'(h);
			r.last = l[0];
			pending.push_back(r);
		endfunction

		function bit put_byte(int c, logic [7:0] d);
			int wp, b;
			if (held[c] > limit || held[c] >= 255) return 0;
			if (!has_blk[c]) begin
				b = grab_block();
				if (b < 0) return 0;
				has_blk[c] = 1;
				wr_pos[c] = b * BBYTES;
				rd_pos[c] = wr_pos[c];
			end
			wp = wr_pos[c] % POOL;
			if (wp % BBYTES == LINK_OFS) begin
				b = grab_block();
				if (b < 0) return 0;
				pool_mem[wp] = b[7:0];
				wp = b * BBYTES;
			end
			pool_mem[wp] = d;
			wr_pos[c] = wp + 1;
			held[c]++;
			return 1;
		endfunction

		function bit get_byte(int c, output logic [7:0] d);
			int rp, lk;
			d = 0;
			if (held[c] == 0 || !has_blk[c]) begin
				held[c] = 0;
				drop_chan(c);
				return 0;
			end
			rp = rd_pos[c] % POOL;
			if (rp % BBYTES == LINK_OFS) begin
				if (rp / BBYTES < NBLK) free_map[rp/BBYTES] = 1;
				lk = pool_mem[rp];
				if (lk >= NBLK) begin
					drop_chan(c);
					held[c] = 0;
					return 0;
				end
				rp = lk * BBYTES;
			end
			d = pool_mem[rp];
			rp++;
			held[c]--;
			if (held[c] == 0) begin
				free_map[(rp-1)/BBYTES] = 1;
				drop_chan(c);
			end else begin
				rd_pos[c] = rp;
			end
			return 1;
		endfunction

		function void note_request(lbcf_pkg::req_t q);
			int c, n, len, rp, lk;
			bit ok;
			logic [7:0] d;
			c = q.channel;
			if (c >= NCH) begin
				push_rsp(0, 0, 0, 0, 1);
				return;
			end
			case (q.command)
				lbcf_pkg::CMD_PUT: begin
					ok = put_byte(c, q.write_byte);
					push_rsp(0, 0, ok, held[c], 1);
				end
				lbcf_pkg::CMD_GET: begin
					ok = get_byte(c, d);
					push_rsp(ok ? d : 8'd0, ok, 0, held[c], 1);
				end
				lbcf_pkg::CMD_PEEK: begin
					len = q.peek_length;
					if (len > MPEEK) len = MPEEK;
					n = has_blk[c] ? held[c] : 0;
					if (n > len) n = len;
					if (n == 0) begin
						push_rsp(0, 0, 0, held[c], 1);
						return;
					end
					rp = rd_pos[c] % POOL;
					for (int i = 0; i < n; i++) begin
						if (rp % BBYTES == LINK_OFS) begin
							lk = pool_mem[rp];
							if (lk >= NBLK) begin
								if (i == 0) push_rsp(0, 0, 0, held[c], 1);
								else pending[pending.size()-1].last = 1;
								return;
							end
							rp = lk * BBYTES;
						end
						push_rsp(pool_mem[rp], 1, 0, held[c], i + 1 == n);
						rp = (rp + 1) % POOL;
					end
				end
				default: push_rsp(0, 0, 0, held[c], 1);
			endcase
		endfunction

		function void check_result(lbcf_pkg::rsp_t r);
			lbcf_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat %p", r);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.read_byte !== e.read_byte) begin
				$error("read_byte exp %0h got %0h", e.read_byte, r.read_byte);
				errors++;
			end
			if (r.byte_valid !== e.byte_valid) begin
				$error("byte_valid exp %0b got %0b", e.byte_valid, r.byte_valid);
				errors++;
			end
			if (r.accepted !== e.accepted) begin
				$error("accepted exp %0b got %0b", e.accepted, r.accepted);
				errors++;
			end
			if (r.bytes_held !== e.bytes_held) begin
				$error("bytes_held exp %0d got %0d", e.bytes_held, r.bytes_held);
				errors++;
			end
			if (r.last !== e.last) begin
				$error("last exp %0b got %0b", e.last, r.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic req_valid, req_ready;
	lbcf_pkg::req_t req;
	logic rsp_valid, rsp_ready;
	lbcf_pkg::rsp_t rsp;

	pool_scoreboard sb;
	int send_idle_pct;
	int stall_pct;
	int cycles;

	linked_block_channel_fifo u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) sb.check_result(rsp);
		rsp_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic write_limit(int v);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'(4 * lbcf_pkg::REG_FILL_LIMIT);
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.limit = v;
	endtask

	// valid stays up between back-to-back items; idling or draining drops it
	task automatic send_item(logic [1:0] cmd, int ch, int d, int len);
		lbcf_pkg::req_t q;
		q.command = cmd;
		q.channel = 2'(ch);
		q.write_byte = 8'(d);
		q.peek_length = 7'(len);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req <= q;
		do @(posedge clk); while (!req_ready);
		sb.note_request(q);
	endtask

	task automatic drain();
		req_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic random_items(int n);
		int k, ch;
		logic [1:0] cmd;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			ch = $urandom_range(NCH - 1);
			if (k < 50) cmd = lbcf_pkg::CMD_PUT;
			else if (k < 80) cmd = lbcf_pkg::CMD_GET;
			else if (k < 95) cmd = lbcf_pkg::CMD_PEEK;
			else cmd = lbcf_pkg::CMD_NONE;
			send_item(cmd, ch, $urandom_range(255), $urandom_range(127));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		req_valid = 0;
		req = '0;
		rsp_ready = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		send_item(lbcf_pkg::CMD_GET, 0, 0, 0);
		send_item(lbcf_pkg::CMD_PEEK, 0, 0, 5);
		for (int i = 0; i < 3; i++) send_item(lbcf_pkg::CMD_PUT, 1, 8'hff - i, 0);
		send_item(lbcf_pkg::CMD_PUT, 1, 8'h00, 0);
		send_item(lbcf_pkg::CMD_PEEK, 1, 0, 0);
		send_item(lbcf_pkg::CMD_PEEK, 1, 0, 7'h7f);
		send_item(lbcf_pkg::CMD_PEEK, 1, 0, 2);
		send_item(lbcf_pkg::CMD_NONE, 1, 8'hff, 7'h7f);
		send_item(lbcf_pkg::CMD_GET, 1, 0, 0);
		send_item(lbcf_pkg::CMD_PUT, 3, 8'h55, 7'h40);
		send_item(lbcf_pkg::CMD_PUT, 2, 8'haa, 7'h01);
		send_item(lbcf_pkg::CMD_GET, 3, 0, 0);
		send_item(lbcf_pkg::CMD_GET, 3, 0, 0);
		drain();

		// fill beyond one block so links are crossed, then exhaust the pool
		write_limit(255);
		for (int i = 0; i < 250; i++) send_item(lbcf_pkg::CMD_PUT, i % 2, i[7:0], 0);
		send_item(lbcf_pkg::CMD_PEEK, 0, 0, 64);
		send_item(lbcf_pkg::CMD_PEEK, 1, 0, 100);
		for (int i = 0; i < 32; i++) send_item(lbcf_pkg::CMD_GET, i % 2, 0, 0);
		drain();
		write_limit(0);
		send_item(lbcf_pkg::CMD_PUT, 2, 8'h11, 0);
		send_item(lbcf_pkg::CMD_PUT, 2, 8'h22, 0);
		send_item(lbcf_pkg::CMD_PUT, 2, 8'h33, 0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 33 : 48) : 0;
			stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 33 : 48) : 0;
			write_limit(ph == 0 ? 40 : (ph == 1 ? 255 : $urandom_range(255)));
			random_items(10);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
